@@ hdl/mcfp_pkg.sv @@
// Package of the management command frame parser: item and result types,
// phase and status codes and the frame constants. No dependencies.
package mcfp_pkg;

    localparam int BYTE_W = 8;

    // Parser phase codes.
    localparam logic [2:0] PH_VERSION = 3'd0;
    localparam logic [2:0] PH_COMMAND = 3'd1;
    localparam logic [2:0] PH_LENGTH  = 3'd2;
    localparam logic [2:0] PH_PAYLOAD = 3'd3;
    localparam logic [2:0] PH_DONE    = 3'd4;
    localparam logic [2:0] PH_ERROR   = 3'd5;

    // Status codes.
    localparam logic [2:0] ST_PENDING = 3'd0;
    localparam logic [2:0] ST_OK      = 3'd1;
    localparam logic [2:0] ST_BAD_VER = 3'd2;
    localparam logic [2:0] ST_BAD_CMD = 3'd3;
    localparam logic [2:0] ST_BAD_LEN = 3'd4;
    localparam logic [2:0] ST_BAD_ARG = 3'd5;

    // Input opcodes.
    localparam logic OP_BYTE    = 1'b0;
    localparam logic OP_RESTART = 1'b1;

    // Configuration register indexes.
    localparam logic CFG_VERSION  = 1'b0;
    localparam logic CFG_CMD_BASE = 1'b1;

    localparam logic [BYTE_W-1:0] DELIM = 8'h3A;

    // Argument counts expected per command index.
    localparam logic [1:0] ARGS_ADD_USER = 2'd2;
    localparam logic [1:0] ARGS_DEL_USER = 2'd1;
    localparam logic [1:0] ARGS_NONE     = 2'd0;

    typedef struct packed {
        logic              opcode;
        logic [BYTE_W-1:0] byte_value;
    } mcfp_item_t;

    typedef struct packed {
        logic [1:0]        args_seen;
        logic              arg_closed;
        logic [BYTE_W-1:0] arg_char;
        logic [BYTE_W-1:0] char_position;
        logic              arg_index;
        logic              char_valid;
        logic [1:0]        command_index;
        logic [2:0]        status;
        logic [2:0]        phase;
        logic              consumed;
    } mcfp_result_t;

endpackage

@@ hdl/mgmt_command_frame_parser.sv @@
// Top level of the management command frame parser.
// Instantiates mcfp_input_reg, mcfp_parse_core and mcfp_output_reg; uses mcfp_pkg.
//
// The parser takes one request per clock while the result side is not stalled
// and returns exactly one result per request, held in the result register.
// A request is either a frame byte (s_tuser = 0) or a restart (s_tuser = 1).
// A frame is a version byte, a command byte, a length byte and a payload of
// colon-separated arguments. Argument characters are not stored: each one
// comes back with its argument index and its position in that argument,
// flagged by m_tuser. Once a frame is done or in error, further bytes are
// refused (consumed = 0) until a restart request arrives. Throughput is one
// request per cycle unless stalled, set by the single parse stage that updates the
// parser state in one step; an input register and a result register separate
// the two sides, so a new request is taken while a finished result still waits.
// Configuration (version byte, command base) is written through the cfg
// channel, which is always ready, and must only be written while idle.
module mgmt_command_frame_parser #(
    parameter int MAX_STRING_LEN = 255,
    parameter int MAX_ARGS       = 2
) (
    input  logic        aclk,
    input  logic        aresetn,
    // Request channel.
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,  // [7:0] byte_value
    input  logic [0:0]  s_tuser,  // [0] opcode
    // Result channel.
    output logic        m_tvalid,
    input  logic        m_tready,
    // [0] consumed, [3:1] phase, [6:4] status, [8:7] command_index,
    // [9] arg_index, [17:10] char_position, [25:18] arg_char,
    // [26] arg_closed, [28:27] args_seen, [31:29] zero
    output logic [31:0] m_tdata,
    output logic [0:0]  m_tuser,  // [0] char_valid
    // Configuration write channel.
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_index,
    input  logic [7:0]  cfg_data
);
    import mcfp_pkg::*;

    mcfp_item_t   s_item;
    mcfp_item_t   item;
    mcfp_result_t result;
    mcfp_result_t m_result;
    logic         item_valid;
    logic         advance;

    assign s_item.opcode     = s_tuser[0];
    assign s_item.byte_value = s_tdata;

    // The held request is parsed when the result register is free or is
    // being emptied in this same cycle.
    assign advance = item_valid && (!m_tvalid || m_tready);

    mcfp_input_reg u_in (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_tvalid),
        .s_ready    (s_tready),
        .s_item     (s_item),
        .advance    (advance),
        .item_valid (item_valid),
        .item       (item)
    );

    mcfp_parse_core #(
        .MAX_STRING_LEN (MAX_STRING_LEN),
        .MAX_ARGS       (MAX_ARGS)
    ) u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .advance   (advance),
        .item      (item),
        .result    (result)
    );

    mcfp_output_reg u_out (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .load     (advance),
        .result   (result),
        .m_valid  (m_tvalid),
        .m_ready  (m_tready),
        .m_result (m_result)
    );

    // Pack the result fields from the lowest bit up; char_valid rides in tuser.
    assign m_tdata = {3'b000,
                      m_result.args_seen,
                      m_result.arg_closed,
                      m_result.arg_char,
                      m_result.char_position,
                      m_result.arg_index,
                      m_result.command_index,
                      m_result.status,
                      m_result.phase,
                      m_result.consumed};
    assign m_tuser = m_result.char_valid;

endmodule

@@ hdl/mcfp_input_reg.sv @@
// Input register of the frame parser: holds one accepted request until the
// parse stage takes it. Depends on mcfp_pkg.
module mcfp_input_reg (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  mcfp_pkg::mcfp_item_t s_item,
    input  logic               advance,
    output logic               item_valid,
    output mcfp_pkg::mcfp_item_t item
);
    import mcfp_pkg::*;

    logic       valid_reg;
    logic       valid_next;
    mcfp_item_t item_reg;

    // Room when empty or when the held request moves on this cycle.
    assign s_ready    = !valid_reg || advance;
    assign valid_next = s_ready ? s_valid : valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            item_reg <= s_item;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

@@ hdl/mcfp_parse_core.sv @@
// Parse stage of the frame parser: configuration and parser state registers
// and the per-byte decision logic. Depends on mcfp_pkg.
module mcfp_parse_core #(
    parameter int MAX_STRING_LEN = 255,
    parameter int MAX_ARGS       = 2
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic                   cfg_index,
    input  logic [7:0]             cfg_data,
    input  logic                   advance,
    input  mcfp_pkg::mcfp_item_t   item,
    output mcfp_pkg::mcfp_result_t result
);
    import mcfp_pkg::*;

    localparam logic [BYTE_W-1:0] MAX_LEN_C  = BYTE_W'(MAX_STRING_LEN);
    localparam logic [1:0]        MAX_ARGS_C = 2'(MAX_ARGS);

    logic [BYTE_W-1:0] version_reg, cmd_base_reg;
    logic [2:0]        phase_reg, phase_next;
    logic [2:0]        status_reg, status_next;
    logic [1:0]        cmd_reg, cmd_next;
    logic [1:0]        expect_reg, expect_next;
    logic [BYTE_W-1:0] left_reg, left_next;
    logic [BYTE_W-1:0] alen_reg, alen_next;
    logic [1:0]        acnt_reg, acnt_next;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            version_reg  <= 8'd1;
            cmd_base_reg <= 8'd0;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                CFG_VERSION:  version_reg  <= cfg_data;
                CFG_CMD_BASE: cmd_base_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    always_comb begin
        logic [BYTE_W-1:0] c;
        logic [BYTE_W:0]   cmd_top;
        logic [BYTE_W-1:0] cmd_off;
        logic              ok;
        logic              consumed, cv, ai, closed;
        logic [BYTE_W-1:0] cp, ch;

        c         = item.byte_value;
        cmd_top   = {1'b0, cmd_base_reg} + 9'd3;
        cmd_off   = c - cmd_base_reg;
        ok        = 1'b1;
        consumed  = 1'b0;
        cv        = 1'b0;
        ai        = 1'b0;
        closed    = 1'b0;
        cp        = '0;
        ch        = '0;

        phase_next  = phase_reg;
        status_next = status_reg;
        cmd_next    = cmd_reg;
        expect_next = expect_reg;
        left_next   = left_reg;
        alen_next   = alen_reg;
        acnt_next   = acnt_reg;

        if (item.opcode == OP_RESTART) begin
            phase_next  = PH_VERSION;
            status_next = ST_PENDING;
            cmd_next    = '0;
            expect_next = '0;
            left_next   = '0;
            alen_next   = '0;
            acnt_next   = '0;
        end else if (phase_reg != PH_DONE && phase_reg != PH_ERROR) begin
            consumed = 1'b1;
            unique case (phase_reg)
                PH_VERSION: begin
                    if (c != version_reg) begin
                        phase_next  = PH_ERROR;
                        status_next = ST_BAD_VER;
                    end else begin
                        phase_next = PH_COMMAND;
                    end
                end
                PH_COMMAND: begin
                    if (c < cmd_base_reg || {1'b0, c} > cmd_top) begin
                        phase_next  = PH_ERROR;
                        status_next = ST_BAD_CMD;
                    end else begin
                        cmd_next = cmd_off[1:0];
                        case (cmd_off[1:0])
                            2'd0:    expect_next = ARGS_ADD_USER;
                            2'd1:    expect_next = ARGS_DEL_USER;
                            default: expect_next = ARGS_NONE;
                        endcase
                        phase_next = PH_LENGTH;
                    end
                end
                PH_LENGTH: begin
                    if (c > MAX_LEN_C) begin
                        phase_next  = PH_ERROR;
                        status_next = ST_BAD_LEN;
                    end else begin
                        left_next = c;
                        if (c == '0 && expect_reg == ARGS_NONE) begin
                            phase_next  = PH_DONE;
                            status_next = ST_OK;
                        end else begin
                            phase_next = PH_PAYLOAD;
                        end
                    end
                end
                PH_PAYLOAD: begin
                    if (left_reg == '0) begin
                        phase_next  = PH_ERROR;
                        status_next = ST_BAD_LEN;
                        ok          = 1'b0;
                    end else if (c == DELIM) begin
                        if (alen_reg == '0 || acnt_reg >= MAX_ARGS_C) begin
                            phase_next  = PH_ERROR;
                            status_next = ST_BAD_ARG;
                            ok          = 1'b0;
                        end else begin
                            acnt_next = acnt_reg + 2'd1;
                            alen_next = '0;
                            closed    = 1'b1;
                        end
                    end else if (alen_reg >= MAX_LEN_C) begin
                        phase_next  = PH_ERROR;
                        status_next = ST_BAD_ARG;
                        ok          = 1'b0;
                    end else begin
                        cv        = 1'b1;
                        ai        = acnt_reg[0];
                        cp        = alen_reg;
                        ch        = c;
                        alen_next = alen_reg + 8'd1;
                    end
                    if (ok) begin
                        left_next = left_reg - 8'd1;
                        // Payload exhausted: close a pending argument, then
                        // check the count against what the command needs.
                        if (left_next == '0) begin
                            if (alen_next != '0) begin
                                if (acnt_next >= MAX_ARGS_C) begin
                                    phase_next  = PH_ERROR;
                                    status_next = ST_BAD_ARG;
                                    ok          = 1'b0;
                                end else begin
                                    acnt_next = acnt_next + 2'd1;
                                    alen_next = '0;
                                    closed    = 1'b1;
                                end
                            end
                            if (ok) begin
                                if (acnt_next != expect_reg) begin
                                    phase_next  = PH_ERROR;
                                    status_next = ST_BAD_ARG;
                                end else begin
                                    phase_next  = PH_DONE;
                                    status_next = ST_OK;
                                end
                            end
                        end
                    end
                end
                default: begin
                    phase_next  = PH_ERROR;
                    status_next = ST_BAD_ARG;
                end
            endcase
        end

        result.consumed      = consumed;
        result.phase         = phase_next;
        result.status        = status_next;
        result.command_index = cmd_next;
        result.char_valid    = cv;
        result.arg_index     = ai;
        result.char_position = cp;
        result.arg_char      = ch;
        result.arg_closed    = closed;
        result.args_seen     = acnt_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg  <= PH_VERSION;
            status_reg <= ST_PENDING;
            cmd_reg    <= '0;
            expect_reg <= '0;
            left_reg   <= '0;
            alen_reg   <= '0;
            acnt_reg   <= '0;
        end else if (advance) begin
            phase_reg  <= phase_next;
            status_reg <= status_next;
            cmd_reg    <= cmd_next;
            expect_reg <= expect_next;
            left_reg   <= left_next;
            alen_reg   <= alen_next;
            acnt_reg   <= acnt_next;
        end
    end

endmodule

@@ hdl/mcfp_output_reg.sv @@
// Result register of the frame parser: holds one result until the
// downstream side takes it. Depends on mcfp_pkg.
module mcfp_output_reg (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   load,
    input  mcfp_pkg::mcfp_result_t result,
    output logic                   m_valid,
    input  logic                   m_ready,
    output mcfp_pkg::mcfp_result_t m_result
);
    import mcfp_pkg::*;

    logic         valid_reg;
    mcfp_result_t result_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (load) begin
            valid_reg <= 1'b1;
        end else if (m_ready) begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            result_reg <= result;
        end
    end

    assign m_valid  = valid_reg;
    assign m_result = result_reg;

endmodule

@@ hdl/mcfp_checker.sv @@
// Port-level checker for the frame parser, bound to the top level.
// Depends on mcfp_pkg.
module mcfp_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [31:0] m_tdata,
    input logic [0:0]  m_tuser
);
    import mcfp_pkg::*;

    // A stalled result holds its contents.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    // A character is only reported for a byte that was taken.
    a_char_consumed: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[0] |-> m_tdata[0])
        else $error("character reported for a refused byte");

    // Without a character the character fields are zero.
    a_char_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser[0] |-> m_tdata[25:9] == 17'd0)
        else $error("character fields set without a character");

    // Success status only goes with the done phase.
    a_ok_done: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[6:4] == ST_OK |-> m_tdata[3:1] == PH_DONE)
        else $error("ok status outside the done phase");

endmodule

bind mgmt_command_frame_parser mcfp_checker u_mcfp_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

@@ dv/mcfp_result_checker.sv @@
// Result checker for the management command frame parser.
// Watches the request, result and configuration channels, predicts each
// result and compares it field by field; uses mcfp_pkg.
module mcfp_result_checker #(
    parameter int MAX_STRING_LEN = 255,
    parameter int MAX_ARGS       = 2
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [7:0]  s_tdata,
    input  logic [0:0]  s_tuser,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [31:0] m_tdata,
    input  logic [0:0]  m_tuser,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic        cfg_index,
    input  logic [7:0]  cfg_data,
    output int          error_total,
    output int          outstanding
);
    import mcfp_pkg::*;

    localparam logic [7:0] VERSION_AT_RESET = 8'd1;
    localparam logic [7:0] BASE_AT_RESET    = 8'd0;

    // Configuration copy.
    logic [7:0] ver_r;
    logic [7:0] base_r;

    // Parser state copy.
    logic [2:0] phase_r;
    logic [2:0] status_r;
    logic [1:0] cmd_r;
    logic [1:0] need_r;
    logic [7:0] left_r;
    logic [7:0] alen_r;
    logic [1:0] argc_r;

    mcfp_result_t expected_q[$];
    mcfp_result_t got;
    mcfp_result_t want;
    int           mismatches = 0;

    function automatic void clear_parser();
        phase_r  = PH_VERSION;
        status_r = ST_PENDING;
        cmd_r    = 2'd0;
        need_r   = 2'd0;
        left_r   = 8'd0;
        alen_r   = 8'd0;
        argc_r   = 2'd0;
    endfunction

    function automatic void flag_error(input logic [2:0] code);
        status_r = code;
        phase_r  = PH_ERROR;
    endfunction

    // Applies one request to the state copy and returns the result it causes.
    function automatic mcfp_result_t parse_byte(input logic op, input logic [7:0] c);
        mcfp_result_t r;
        logic         ok;
        logic [7:0]   diff;
        r = '0;
        if (op == OP_RESTART) begin
            clear_parser();
        end else if (phase_r != PH_DONE && phase_r != PH_ERROR) begin
            r.consumed = 1'b1;
            case (phase_r)
                PH_VERSION: begin
                    if (c != ver_r) flag_error(ST_BAD_VER);
                    else phase_r = PH_COMMAND;
                end
                PH_COMMAND: begin
                    if (int'(c) < int'(base_r) || int'(c) > int'(base_r) + 3) begin
                        flag_error(ST_BAD_CMD);
                    end else begin
                        diff  = c - base_r;
                        cmd_r = diff[1:0];
                        case (cmd_r)
                            2'd0:    need_r = ARGS_ADD_USER;
                            2'd1:    need_r = ARGS_DEL_USER;
                            default: need_r = ARGS_NONE;
                        endcase
                        phase_r = PH_LENGTH;
                    end
                end
                PH_LENGTH: begin
                    if (int'(c) > MAX_STRING_LEN) begin
                        flag_error(ST_BAD_LEN);
                    end else begin
                        left_r = c;
                        if (c == 8'd0 && need_r == 2'd0) begin
                            status_r = ST_OK;
                            phase_r  = PH_DONE;
                        end else begin
                            phase_r = PH_PAYLOAD;
                        end
                    end
                end
                PH_PAYLOAD: begin
                    ok = 1'b1;
                    if (left_r == 8'd0) begin
                        flag_error(ST_BAD_LEN);
                        ok = 1'b0;
                    end else if (c == DELIM) begin
                        if (alen_r == 8'd0 || int'(argc_r) >= MAX_ARGS) begin
                            flag_error(ST_BAD_ARG);
                            ok = 1'b0;
                        end else begin
                            argc_r       = argc_r + 2'd1;
                            alen_r       = 8'd0;
                            r.arg_closed = 1'b1;
                        end
                    end else if (int'(alen_r) >= MAX_STRING_LEN) begin
                        flag_error(ST_BAD_ARG);
                        ok = 1'b0;
                    end else begin
                        r.char_valid    = 1'b1;
                        r.arg_index     = argc_r[0];
                        r.char_position = alen_r;
                        r.arg_char      = c;
                        alen_r          = alen_r + 8'd1;
                    end
                    if (ok) begin
                        left_r = left_r - 8'd1;
                        if (left_r == 8'd0) begin
                            // The last argument is closed by the end of the payload.
                            if (alen_r != 8'd0) begin
                                if (int'(argc_r) >= MAX_ARGS) begin
                                    flag_error(ST_BAD_ARG);
                                    ok = 1'b0;
                                end else begin
                                    argc_r       = argc_r + 2'd1;
                                    alen_r       = 8'd0;
                                    r.arg_closed = 1'b1;
                                end
                            end
                            if (ok) begin
                                if (argc_r != need_r) begin
                                    flag_error(ST_BAD_ARG);
                                end else begin
                                    status_r = ST_OK;
                                    phase_r  = PH_DONE;
                                end
                            end
                        end
                    end
                end
                default: flag_error(ST_BAD_ARG);
            endcase
        end
        r.phase         = phase_r;
        r.status        = status_r;
        r.command_index = cmd_r;
        r.args_seen     = argc_r;
        return r;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("[%0t] mismatch: %s", $time, msg);
        mismatches++;
    endtask

    task automatic compare_field(input string name, input int seen, input int wanted);
        if (seen != wanted) begin
            report_mismatch($sformatf("%s got %0d, expected %0d", name, seen, wanted));
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            ver_r  = VERSION_AT_RESET;
            base_r = BASE_AT_RESET;
            clear_parser();
            expected_q.delete();
        end else begin
            if (cfg_valid && cfg_ready) begin
                if (cfg_index == CFG_VERSION) ver_r = cfg_data;
                else base_r = cfg_data;
            end
            if (s_tvalid && s_tready) begin
                expected_q.push_back(parse_byte(s_tuser[0], s_tdata));
            end
            if (m_tvalid && m_tready) begin
                if (expected_q.size() == 0) begin
                    report_mismatch($sformatf("result 0x%08h with nothing expected", m_tdata));
                end else begin
                    want              = expected_q.pop_front();
                    got.consumed      = m_tdata[0];
                    got.phase         = m_tdata[3:1];
                    got.status        = m_tdata[6:4];
                    got.command_index = m_tdata[8:7];
                    got.arg_index     = m_tdata[9];
                    got.char_position = m_tdata[17:10];
                    got.arg_char      = m_tdata[25:18];
                    got.arg_closed    = m_tdata[26];
                    got.args_seen     = m_tdata[28:27];
                    got.char_valid    = m_tuser[0];
                    compare_field("consumed", got.consumed, want.consumed);
                    compare_field("phase", got.phase, want.phase);
                    compare_field("status", got.status, want.status);
                    compare_field("command_index", got.command_index, want.command_index);
                    compare_field("char_valid", got.char_valid, want.char_valid);
                    compare_field("arg_index", got.arg_index, want.arg_index);
                    compare_field("char_position", got.char_position, want.char_position);
                    compare_field("arg_char", got.arg_char, want.arg_char);
                    compare_field("arg_closed", got.arg_closed, want.arg_closed);
                    compare_field("args_seen", got.args_seen, want.args_seen);
                end
            end
        end
        outstanding <= expected_q.size();
        error_total <= mismatches;
    end

endmodule

@@ dv/mgmt_command_frame_parser_tb.sv @@
// Top of the management command frame parser testbench: clock, reset,
// request and configuration stimulus and the verdict. Depends on mcfp_pkg,
// mgmt_command_frame_parser and mcfp_result_checker.
module mgmt_command_frame_parser_tb;
    import mcfp_pkg::*;

    localparam int ARG_LEN_MAX  = 255;
    localparam int ARGS_MAX     = 2;
    localparam int PHASE_ITEMS  = 100;
    localparam int HOLD_CYCLES  = 120;

    logic        aclk;
    logic        aresetn   = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata   = 8'd0;
    logic [0:0]  s_tuser   = 1'b0;
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [31:0] m_tdata;
    logic [0:0]  m_tuser;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic        cfg_index = 1'b0;
    logic [7:0]  cfg_data  = 8'd0;

    int error_total;
    int outstanding;

    // Stimulus knobs: idle percentages of the two sides and a long hold-off
    // of the result side.
    int   src_idle_pct = 0;
    int   dst_idle_pct = 0;
    logic sink_hold    = 1'b0;
    int   items_sent   = 0;

    // The configuration the frames are built against; the checker keeps its
    // own copy from the configuration channel.
    logic [7:0] cur_ver  = 8'd1;
    logic [7:0] cur_base = 8'd0;

    // Bytes of the frame about to be sent, restart not included.
    logic [7:0] frame_q[$];

    mgmt_command_frame_parser #(
        .MAX_STRING_LEN(ARG_LEN_MAX),
        .MAX_ARGS      (ARGS_MAX)
    ) dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data)
    );

    mcfp_result_checker #(
        .MAX_STRING_LEN(ARG_LEN_MAX),
        .MAX_ARGS      (ARGS_MAX)
    ) u_checker (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .error_total(error_total),
        .outstanding(outstanding)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    // The result side takes a result in all but dst_idle_pct percent of the
    // cycles, and never while the hold-off is active.
    always @(posedge aclk) begin
        m_tready <= !sink_hold && ($urandom_range(0, 99) >= dst_idle_pct);
    end

    // Offers one request and returns at the edge where it is taken. The valid
    // line only drops for idle cycles, so back-to-back requests keep it high.
    task automatic push_request(input logic op, input logic [7:0] value);
        while ($urandom_range(0, 99) < src_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= value;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        items_sent++;
    endtask

    // Every frame starts with a restart request so that the sticky done and
    // error states of the previous frame are cleared.
    task automatic send_frame_bytes();
        push_request(OP_RESTART, 8'($urandom));
        foreach (frame_q[i]) push_request(OP_BYTE, frame_q[i]);
    endtask

    // Waits until every request has its result back. The first edge lets the
    // checker's count catch up with a request taken at the current edge.
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (outstanding != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_reg(input logic idx, input logic [7:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [7:0] random_arg_char();
        logic [7:0] b;
        b = 8'($urandom);
        if (b == DELIM) b = ~b;
        return b;
    endfunction

    // Builds one frame into frame_q. Most kinds are well formed with random
    // content; the rest break the frame in one particular way.
    task automatic build_frame(input int kind);
        logic [7:0] pay[$];
        logic [7:0] ver;
        logic [7:0] cmd;
        int         k;
        int         nargs;
        int         alen;
        int         a;
        int         split_at;
        int         cut;
        ver      = cur_ver;
        k        = $urandom_range(0, 3);
        cmd      = cur_base + 8'(k);
        nargs    = (k == 0) ? 2 : (k == 1) ? 1 : 0;
        split_at = -1;
        case (kind)
            12: ver = cur_ver ^ 8'($urandom_range(1, 255));
            13: begin
                // Any code outside base..base+3, below the base included.
                do cmd = 8'($urandom);
                while (int'(cmd) >= int'(cur_base) && int'(cmd) <= int'(cur_base) + 3);
            end
            14: begin
                // Zero length although the command expects arguments; the
                // next byte then finds no length left.
                k     = $urandom_range(0, 1);
                cmd   = cur_base + 8'(k);
                nargs = 0;
            end
            15: begin
                cmd   = cur_base;
                nargs = 2;
            end
            16: nargs = $urandom_range(3, 4);
            17: begin
                do a = $urandom_range(0, 2);
                while (a == nargs);
                nargs = a;
            end
            default: ;
        endcase
        for (a = 0; a < nargs; a++) begin
            if (a > 0) begin
                if (split_at < 0) split_at = pay.size();
                pay.push_back(DELIM);
            end
            alen = ($urandom_range(0, 7) == 0) ? $urandom_range(6, 24) : $urandom_range(1, 5);
            repeat (alen) pay.push_back(random_arg_char());
        end
        // An empty argument, either leading or between two delimiters.
        if (kind == 15) begin
            if ($urandom_range(0, 1) == 0) pay.insert(0, DELIM);
            else pay.insert(split_at, DELIM);
        end
        // A trailing delimiter now and then: harmless while the count works out.
        if (kind < 12 && nargs > 0 && $urandom_range(0, 11) == 0) pay.push_back(DELIM);
        frame_q.delete();
        frame_q.push_back(ver);
        frame_q.push_back(cmd);
        frame_q.push_back(8'(pay.size()));
        foreach (pay[i]) frame_q.push_back(pay[i]);
        if (kind == 14) frame_q.push_back(8'($urandom));
        // A frame cut short by the next restart.
        if (kind == 18) begin
            cut = $urandom_range(1, frame_q.size() - 1);
            while (frame_q.size() > cut) void'(frame_q.pop_back());
        end
    endtask

    // One argument of the greatest length, reaching the last character position.
    task automatic build_long_frame();
        frame_q.delete();
        frame_q.push_back(cur_ver);
        frame_q.push_back(cur_base + 8'd1);
        frame_q.push_back(8'(ARG_LEN_MAX));
        repeat (ARG_LEN_MAX) frame_q.push_back(random_arg_char());
    endtask

    // Drains the parser, sets the configuration and idling, then sends random
    // frames and noise until the phase has its share of requests. The phase
    // with the hold-off first sends one frame with the longest argument.
    task automatic run_phase(input int src_pct, input int dst_pct, input logic [7:0] ver,
                             input logic [7:0] base, input logic with_hold);
        int first;
        int kind;
        wait_idle();
        write_reg(CFG_VERSION, ver);
        write_reg(CFG_CMD_BASE, base);
        cur_ver      = ver;
        cur_base     = base;
        src_idle_pct = src_pct;
        dst_idle_pct = dst_pct;
        if (with_hold) begin
            // The result side stops for a long while; the sender keeps
            // offering until the parser fills up and drops s_tready.
            fork
                begin
                    sink_hold <= 1'b1;
                    repeat (HOLD_CYCLES) @(posedge aclk);
                    sink_hold <= 1'b0;
                end
            join_none
            build_long_frame();
            send_frame_bytes();
        end
        first = items_sent;
        while (items_sent - first < PHASE_ITEMS) begin
            kind = $urandom_range(0, 19);
            if (kind == 19) begin
                repeat ($urandom_range(1, 6)) begin
                    push_request(($urandom_range(0, 9) == 0) ? OP_RESTART : OP_BYTE,
                                 8'($urandom));
                end
            end else begin
                build_frame(kind);
                send_frame_bytes();
                // Bytes past the end of a finished frame are refused.
                if ($urandom_range(0, 3) == 0) begin
                    repeat ($urandom_range(1, 2)) push_request(OP_BYTE, 8'($urandom));
                end
            end
        end
    endtask

    initial begin
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed frames against the reset configuration: version 1, base 0.
        src_idle_pct = 24;
        dst_idle_pct = 47;
        // Wrong version, then a byte refused after the error.
        frame_q = '{8'h00, 8'hFF};
        send_frame_bytes();
        // A command without arguments and an empty payload finishes at the length byte.
        frame_q = '{8'h01, 8'h03, 8'h00};
        send_frame_bytes();
        // Delete user with a one-character argument of the highest value.
        frame_q = '{8'h01, 8'h01, 8'h01, 8'hFF};
        send_frame_bytes();
        // Command code just above the range.
        frame_q = '{8'h01, 8'h04};
        send_frame_bytes();
        // Zero length for add user: the payload byte finds no length left.
        frame_q = '{8'h01, 8'h00, 8'h00, 8'h78};
        send_frame_bytes();
        // Leading delimiter gives an empty argument.
        frame_q = '{8'h01, 8'h00, 8'h03, DELIM};
        send_frame_bytes();
        // Add user with two short arguments.
        frame_q = '{8'h01, 8'h00, 8'h03, 8'h00, DELIM, 8'h62};
        send_frame_bytes();

        run_phase(24, 47, 8'($urandom), 8'($urandom_range(1, 251)), 1'b0);
        run_phase(47, 24, 8'hFF, 8'd252, 1'b0);
        run_phase(0, 0, 8'h00, 8'h00, 1'b1);

        wait_idle();
        repeat (8) @(posedge aclk);
        if (error_total == 0) begin
            $display("mgmt_command_frame_parser_tb passed");
        end else begin
            $display("mgmt_command_frame_parser_tb failed");
        end
        $finish;
    end

    // Far beyond the slowest correct run.
    initial begin
        #400000;
        $display("mgmt_command_frame_parser_tb failed");
        $finish;
    end

endmodule

@@ files.f @@
hdl/mcfp_pkg.sv
hdl/mcfp_input_reg.sv
hdl/mcfp_parse_core.sv
hdl/mcfp_output_reg.sv
hdl/mgmt_command_frame_parser.sv
hdl/mcfp_checker.sv
dv/mcfp_result_checker.sv
dv/mgmt_command_frame_parser_tb.sv
